>>> hw/rtl/gift128_pkg.sv
`default_nettype none

package gift128_pkg;

  localparam int ROUND_COUNT = 40;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD3 = 3'd3;

  localparam logic [31:0] TOP_BIT = 32'h8000_0000;

  localparam logic [7:0] RC_TABLE [40] = '{
    8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3E, 8'h3D, 8'h3B, 8'h37, 8'h2F,
    8'h1E, 8'h3C, 8'h39, 8'h33, 8'h27, 8'h0E, 8'h1D, 8'h3A, 8'h35, 8'h2B,
    8'h16, 8'h2C, 8'h18, 8'h30, 8'h21, 8'h02, 8'h05, 8'h0B, 8'h17, 8'h2E,
    8'h1C, 8'h38, 8'h31, 8'h23, 8'h06, 8'h0D, 8'h1B, 8'h36, 8'h2D, 8'h1A
  };

  typedef logic [3:0][31:0] slices_t;

  // Cipher state and the working copy of the key travel together.
  typedef struct packed {
    slices_t k;
    slices_t s;
  } stage_t;

  function automatic logic [31:0] swap_move(logic [31:0] w, int sh, logic [31:0] mask);
    logic [31:0] t;
    t = (w ^ (w >> sh)) & mask;
    return w ^ t ^ (t << sh);
  endfunction

  function automatic logic [31:0] slice_mix(logic [31:0] w);
    logic [31:0] x;
    x = swap_move(w, 3, 32'h0842_0842);
    x = swap_move(x, 6, 32'h0084_0084);
    x = swap_move(x, 9, 32'h0008_0008);
    x = {x[31:24], x[15:8], x[23:16], x[7:0]};
    x = swap_move(x, 4, 32'h00f0_00f0);
    return x;
  endfunction

  // High half rotates right by 2, low half right by 12.
  function automatic logic [31:0] key_rotate(logic [31:0] w);
    return {w[17:16], w[31:18], w[11:0], w[15:12]};
  endfunction

  function automatic stage_t gift_round(stage_t cur, logic [1:0] ia, logic [1:0] ku,
                                        logic [1:0] kv, logic [7:0] rc);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [1:0]  id;
    stage_t      nxt;
    id = 2'd3 - ia;
    a = cur.s[ia];
    b = cur.s[1];
    c = cur.s[2];
    d = cur.s[id];

    b = b ^ (a & c);
    a = a ^ (b & d);
    c = c ^ (a | b);
    d = d ^ c;
    b = b ^ d;
    c = c ^ (a & b);
    d = ~d;

    a = slice_mix(a);
    b = slice_mix(b);
    c = slice_mix(c);
    d = slice_mix(d);
    d = {d[15:8], d[23:16], d[31:24], d[7:0]};
    b = {b[23:16], b[31:24], b[7:0], b[15:8]};
    c = {c[31:24], c[7:0], c[15:8], c[23:16]};
    a = {a[7:0], a[15:8], a[23:16], a[31:24]};

    c = c ^ cur.k[ku];
    b = b ^ cur.k[kv];
    a = a ^ TOP_BIT ^ {24'd0, rc};

    nxt = cur;
    nxt.k[kv] = key_rotate(cur.k[kv]);
    nxt.s[ia] = a;
    nxt.s[1] = b;
    nxt.s[2] = c;
    nxt.s[id] = d;
    return nxt;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gift128_block_encrypt_top.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_plain_slice0..3, 32 bits each
// out       output     out_valid / out_stall out_cipher_slice0..3, 32 bits each
// cfg       input      cfg_wr_en             cfg_index, cfg_wdata (key words 0..3)
//
// One round per pipeline stage: a result is offered by the last stage register once the block
// has passed every round; one block per cycle is sustained while no result is held at the
// output. A block caught in the input skid register waits there until the pipeline moves
// again.
// The key is copied at entry and rotated along with the block, stage by stage.
// Reset (rst_n low, synchronous) empties the pipeline and the skid register, clears the key.
// A held result at the output freezes the whole pipeline; in_stall is registered and rises
// only once the skid register has caught a block.
`default_nettype none

module gift128_block_encrypt_top (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wr_en,
  input  wire [gift128_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [31:0]                          cfg_wdata,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire [31:0]                          in_plain_slice0,
  input  wire [31:0]                          in_plain_slice1,
  input  wire [31:0]                          in_plain_slice2,
  input  wire [31:0]                          in_plain_slice3,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [31:0]                         out_cipher_slice0,
  output logic [31:0]                         out_cipher_slice1,
  output logic [31:0]                         out_cipher_slice2,
  output logic [31:0]                         out_cipher_slice3
);

  localparam int LAST = gift128_pkg::ROUND_COUNT - 1;

  gift128_pkg::slices_t key_r;
  gift128_pkg::slices_t skid_r;
  logic                 skid_full_r;
  logic                 adv;
  logic                 src_valid;
  gift128_pkg::stage_t  entry_c;
  gift128_pkg::stage_t  stage_r [gift128_pkg::ROUND_COUNT];
  logic                 valid_r [gift128_pkg::ROUND_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gift128_pkg::REG_KEY_WORD0: key_r[0] <= cfg_wdata;
        gift128_pkg::REG_KEY_WORD1: key_r[1] <= cfg_wdata;
        gift128_pkg::REG_KEY_WORD2: key_r[2] <= cfg_wdata;
        gift128_pkg::REG_KEY_WORD3: key_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline moves as one unless the finished block at its end is held.
  assign adv       = !(valid_r[LAST] && out_stall);
  assign in_stall  = skid_full_r;
  assign src_valid = skid_full_r || in_valid;

  always_comb begin
    entry_c.k = key_r;
    if (skid_full_r) begin
      entry_c.s = skid_r;
    end else begin
      entry_c.s = {in_plain_slice3, in_plain_slice2, in_plain_slice1, in_plain_slice0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (adv) begin
        skid_full_r <= 1'b0;
      end
    end else if (in_valid && !adv) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r && in_valid && !adv) begin
      skid_r <= {in_plain_slice3, in_plain_slice2, in_plain_slice1, in_plain_slice0};
    end
  end

  for (genvar r = 0; r < gift128_pkg::ROUND_COUNT; r++) begin : g_round
    localparam logic [1:0] IA = (r % 2 == 1) ? 2'd3 : 2'd0;
    localparam logic [1:0] KU = 2'((1 + 3 * r) % 4);
    localparam logic [1:0] KV = 2'((3 + 3 * r) % 4);

    gift128_pkg::stage_t prev_c;
    gift128_pkg::stage_t next_c;
    logic                prev_valid;

    if (r == 0) begin : g_first
      assign prev_c     = entry_c;
      assign prev_valid = src_valid;
    end else begin : g_next
      assign prev_c     = stage_r[r-1];
      assign prev_valid = valid_r[r-1];
    end

    assign next_c = gift128_pkg::gift_round(prev_c, IA, KU, KV, gift128_pkg::RC_TABLE[r]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[r] <= 1'b0;
      end else if (adv) begin
        valid_r[r] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stage_r[r] <= next_c;
      end
    end
  end

  assign out_valid         = valid_r[LAST];
  assign out_cipher_slice0 = stage_r[LAST].s[0];
  assign out_cipher_slice1 = stage_r[LAST].s[1];
  assign out_cipher_slice2 = stage_r[LAST].s[2];
  assign out_cipher_slice3 = stage_r[LAST].s[3];

`ifndef NO_ASSERTIONS
  // A block taken while the pipeline is frozen must land in the skid register.
  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !adv) |=> skid_full_r)
    else $error("block taken during a freeze was not caught by the skid register");

  // A parked block enters the first round as soon as the pipeline moves.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_full_r && adv) |=> (valid_r[0] && !skid_full_r))
    else $error("skid register did not drain into the first stage");

  // While frozen, neither end of the pipeline may gain or drop a block.
  a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(valid_r[0]) && $stable(valid_r[LAST])))
    else $error("pipeline valid bits changed during a freeze");

  // A delivered result is followed by whatever occupied the stage before the last one.
  a_shift_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && out_valid && !out_stall) |=> (out_valid == $past(valid_r[LAST-1])))
    else $error("pipeline did not shift after a result transfer");
`endif

endmodule

`default_nettype wire

>>> verif/gift128_block_encrypt_checker.sv
module gift128_block_encrypt_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [gift128_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                         cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [31:0]                         in_plain_slice0,
  input  logic [31:0]                         in_plain_slice1,
  input  logic [31:0]                         in_plain_slice2,
  input  logic [31:0]                         in_plain_slice3,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [31:0]                         out_cipher_slice0,
  input  logic [31:0]                         out_cipher_slice1,
  input  logic [31:0]                         out_cipher_slice2,
  input  logic [31:0]                         out_cipher_slice3,
  output int                                  error_count,
  output int                                  pending,
  output int                                  blocks_checked
);

  localparam int REPORT_CAP = 24;

  localparam logic [7:0] RC_BYTES [40] = '{
    8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3E, 8'h3D, 8'h3B, 8'h37, 8'h2F,
    8'h1E, 8'h3C, 8'h39, 8'h33, 8'h27, 8'h0E, 8'h1D, 8'h3A, 8'h35, 8'h2B,
    8'h16, 8'h2C, 8'h18, 8'h30, 8'h21, 8'h02, 8'h05, 8'h0B, 8'h17, 8'h2E,
    8'h1C, 8'h38, 8'h31, 8'h23, 8'h06, 8'h0D, 8'h1B, 8'h36, 8'h2D, 8'h1A
  };

  logic [3:0][31:0] key_copy;
  logic [127:0]     cipher_q [$];

  initial begin
    error_count    = 0;
    pending        = 0;
    blocks_checked = 0;
    key_copy       = '0;
  end

  function automatic logic [31:0] swap_bits(input logic [31:0] w, input int sh,
                                            input logic [31:0] m);
    logic [31:0] t;
    t = (w ^ (w >> sh)) & m;
    return w ^ t ^ (t << sh);
  endfunction

  // Byte j of the result is byte sel_j of the word.
  function automatic logic [31:0] pick_bytes(input logic [31:0] w, input int sel0,
                                             input int sel1, input int sel2, input int sel3);
    return {w[8*sel3 +: 8], w[8*sel2 +: 8], w[8*sel1 +: 8], w[8*sel0 +: 8]};
  endfunction

  function automatic logic [31:0] permute_slice(input logic [31:0] w);
    logic [31:0] x;
    x = swap_bits(w, 3, 32'h0842_0842);
    x = swap_bits(x, 6, 32'h0084_0084);
    x = swap_bits(x, 9, 32'h0008_0008);
    x = pick_bytes(x, 0, 2, 1, 3);
    return swap_bits(x, 4, 32'h00f0_00f0);
  endfunction

  function automatic logic [31:0] rotate_key_halves(input logic [31:0] w);
    logic [15:0] hi;
    logic [15:0] lo;
    hi = w[31:16];
    lo = w[15:0];
    return {hi[1:0], hi[15:2], lo[11:0], lo[15:12]};
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] plain,
                                                 input logic [127:0] key);
    logic [31:0] st [4];
    logic [31:0] kw [4];
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    int          ia;
    int          id;
    int          ku;
    int          kv;
    for (int i = 0; i < 4; i++) begin
      st[i] = plain[32*i +: 32];
      kw[i] = key[32*i +: 32];
    end
    for (int r = 0; r < gift128_pkg::ROUND_COUNT; r++) begin
      // Slices 0 and 3 trade places as the first S-box input on odd rounds.
      ia = (r % 2 == 1) ? 3 : 0;
      id = 3 - ia;
      ku = (1 + 3 * r) % 4;
      kv = (3 + 3 * r) % 4;
      a = st[ia];
      b = st[1];
      c = st[2];
      d = st[id];

      b = b ^ (a & c);
      a = a ^ (b & d);
      c = c ^ (a | b);
      d = d ^ c;
      b = b ^ d;
      c = c ^ (a & b);
      d = ~d;

      a = pick_bytes(permute_slice(a), 3, 2, 1, 0);
      b = pick_bytes(permute_slice(b), 1, 0, 3, 2);
      c = pick_bytes(permute_slice(c), 2, 1, 0, 3);
      d = pick_bytes(permute_slice(d), 0, 3, 2, 1);

      c = c ^ kw[ku];
      b = b ^ kw[kv];
      a = a ^ {1'b1, 31'd0} ^ {24'd0, RC_BYTES[r % 40]};
      kw[kv] = rotate_key_halves(kw[kv]);

      st[ia] = a;
      st[1]  = b;
      st[2]  = c;
      st[id] = d;
    end
    return {st[3], st[2], st[1], st[0]};
  endfunction

  always @(posedge clk) begin : watch
    logic [127:0] want;
    logic [127:0] got;
    if (!rst_n) begin
      key_copy = '0;
      cipher_q.delete();
    end else begin
      if ($isunknown(out_valid)) begin
        error_count++;
        if (error_count <= REPORT_CAP)
          $display("%0t: out_valid unknown, expected 0 or 1, actual %b", $time, out_valid);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        got = {out_cipher_slice3, out_cipher_slice2, out_cipher_slice1, out_cipher_slice0};
        if (cipher_q.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_CAP)
            $display("%0t: unexpected result, expected none, actual %032h", $time, got);
        end else begin
          want = cipher_q.pop_front();
          blocks_checked++;
          for (int i = 0; i < 4; i++) begin
            if (got[32*i +: 32] !== want[32*i +: 32]) begin
              error_count++;
              if (error_count <= REPORT_CAP)
                $display("%0t: cipher_slice%0d expected %08h actual %08h", $time, i,
                         want[32*i +: 32], got[32*i +: 32]);
            end
          end
        end
      end
      // A block is keyed on the edge of its transfer.
      if (in_valid === 1'b1 && in_stall === 1'b0)
        cipher_q.push_back(encrypt_block({in_plain_slice3, in_plain_slice2,
                                          in_plain_slice1, in_plain_slice0}, key_copy));
      if (cfg_wr_en === 1'b1 && cfg_index <= gift128_pkg::REG_KEY_WORD3)
        key_copy[cfg_index[1:0]] = cfg_wdata;
    end
    pending <= cipher_q.size();
  end

endmodule

>>> verif/tb.sv
module tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_BLOCKS = 212;
  localparam logic [gift128_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [gift128_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_plain_slice0 = '0;
  logic [31:0] in_plain_slice1 = '0;
  logic [31:0] in_plain_slice2 = '0;
  logic [31:0] in_plain_slice3 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_cipher_slice0;
  logic [31:0] out_cipher_slice1;
  logic [31:0] out_cipher_slice2;
  logic [31:0] out_cipher_slice3;

  logic        stall_on = 1'b0;
  int          error_count;
  int          pending;
  int          blocks_checked;
  int          cycles = 0;
  int          key_settings = 0;

  gift128_block_encrypt_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_plain_slice0   (in_plain_slice0),
    .in_plain_slice1   (in_plain_slice1),
    .in_plain_slice2   (in_plain_slice2),
    .in_plain_slice3   (in_plain_slice3),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cipher_slice0 (out_cipher_slice0),
    .out_cipher_slice1 (out_cipher_slice1),
    .out_cipher_slice2 (out_cipher_slice2),
    .out_cipher_slice3 (out_cipher_slice3)
  );

  gift128_block_encrypt_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_plain_slice0   (in_plain_slice0),
    .in_plain_slice1   (in_plain_slice1),
    .in_plain_slice2   (in_plain_slice2),
    .in_plain_slice3   (in_plain_slice3),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cipher_slice0 (out_cipher_slice0),
    .out_cipher_slice1 (out_cipher_slice1),
    .out_cipher_slice2 (out_cipher_slice2),
    .out_cipher_slice3 (out_cipher_slice3),
    .error_count       (error_count),
    .pending           (pending),
    .blocks_checked    (blocks_checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin : stall_gen
    int stall_left;
    int pick;
    if (!rst_n || !stall_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = (pick < 93) ? $urandom_range(0, 3) : $urandom_range(8, 40);
      end
    end
  end

  function automatic logic [127:0] random_plain();
    logic [127:0] v;
    case ($urandom_range(0, 9))
      0: v = 128'd1 << $urandom_range(0, 127);
      1: v = ~(128'd1 << $urandom_range(0, 127));
      2: v = {{32{$urandom_range(0, 1) == 1}}, {32{$urandom_range(0, 1) == 1}},
              {32{$urandom_range(0, 1) == 1}}, {32{$urandom_range(0, 1) == 1}}};
      default: v = {$urandom, $urandom, $urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [127:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Holds the block until its transfer.
  task automatic send_block(input logic [127:0] plain);
    in_valid        <= 1'b1;
    in_plain_slice0 <= plain[31:0];
    in_plain_slice1 <= plain[63:32];
    in_plain_slice2 <= plain[95:64];
    in_plain_slice3 <= plain[127:96];
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Loads all four key words; optionally follows with a write to an unmapped index.
  task automatic write_keys(input logic [127:0] key, input bit stray);
    logic [gift128_pkg::CFG_INDEX_W-1:0] slot [4];
    slot = '{gift128_pkg::REG_KEY_WORD0, gift128_pkg::REG_KEY_WORD1,
             gift128_pkg::REG_KEY_WORD2, gift128_pkg::REG_KEY_WORD3};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= slot[i];
      cfg_wdata <= key[32*i +: 32];
      @(posedge clk);
    end
    if (stray) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_UNMAPPED + 3'($urandom_range(0, 3));
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    key_settings++;
  endtask

  initial begin
    bit gaps_on;
    int gap;
    int pick;
    logic [127:0] key;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The key after reset is all zero.
    send_block('0);
    send_block('1);
    send_block({32'haaaaaaaa, 32'h55555555, 32'h0f0f0f0f, 32'hf0f0f0f0});

    wait_idle(4);
    write_keys('1, 1'b0);
    send_block('0);
    send_block('1);

    wait_idle(4);
    write_keys(128'h00010203_04050607_08090a0b_0c0d0e0f, 1'b1);
    stall_on <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      send_block(128'd1 << (32 * i));
      send_block(128'd1 << (32 * i + 31));
    end
    send_block(random_plain());
    send_block(random_plain());

    wait_idle(4);
    write_keys({4{32'h80000001}}, 1'b1);
    send_block(~128'd1);
    send_block(random_plain());

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle(4);
      case (phase)
        1:       key = '0;
        2:       key = '1;
        5:       key = 128'd1 << $urandom_range(0, 127);
        default: key = random_key();
      endcase
      write_keys(key, phase % 2 == 1);
      // Two phases run back to back with neither side idling.
      gaps_on = !(phase == 2 || phase == 5);
      stall_on <= gaps_on;
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        if (phase == 3 && n % 25 == 24)
          wait_idle(0);
        if (gaps_on) begin
          pick = $urandom_range(0, 99);
          if (pick < 60)
            gap = 0;
          else if (pick < 90)
            gap = $urandom_range(1, 3);
          else if (pick < 97)
            gap = $urandom_range(4, 10);
          else
            gap = $urandom_range(20, 40);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        send_block(random_plain());
      end
    end

    wait_idle(60);
    $display("summary: %0d blocks compared under %0d key settings, including stray writes,",
             blocks_checked, key_settings);
    $display("summary: random gaps and stalls, back-to-back runs and drain pauses.");
    if (error_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> gift128_block_encrypt_top.f
hw/rtl/gift128_pkg.sv
hw/rtl/gift128_block_encrypt_top.sv
verif/gift128_block_encrypt_checker.sv
verif/tb.sv
